@@ sv/shannon_stream_cipher_mac_assert.svh @@
// ----------------------------------------------------------------------------
// Shannon cipher engine assertion macros
// Concurrent check macros used by the top level; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef SHANNON_STREAM_CIPHER_MAC_ASSERT_SVH
`define SHANNON_STREAM_CIPHER_MAC_ASSERT_SVH

`ifndef ASSERT_OFF
`define SHN_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("shannon check failed");
`define SHN_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("shannon sequence check failed");
`else
`define SHN_ASSERT(label, prop)
`define SHN_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ sv/shn_pkg.sv @@
// ----------------------------------------------------------------------------
// Shannon cipher engine package
// Constants, command codes, control struct and the nonlinear functions.
// ----------------------------------------------------------------------------
package shn_pkg;

   localparam int REG_WORDS      = 16;
   localparam int KEYP           = 13;
   localparam int MAX_MAC_BYTES  = 64;
   localparam int MAX_RESULTS    = 16;
   localparam int MAC_BYTE_LIMIT = (MAX_MAC_BYTES < 4 * MAX_RESULTS) ?
                                   MAX_MAC_BYTES : 4 * MAX_RESULTS;
   localparam int DIFF_W         = $clog2(REG_WORDS);
   localparam logic [31:0] INITKONST = 32'h6996c53a;

   typedef logic [31:0] word_type;
   typedef word_type [REG_WORDS-1:0] sreg_type;

   typedef enum logic [2:0] {
      OP_KEY_START   = 3'd0,
      OP_NONCE_START = 3'd1,
      OP_LOAD_BYTE   = 3'd2,
      OP_LOAD_END    = 3'd3,
      OP_ENCRYPT     = 3'd4,
      OP_DECRYPT     = 3'd5,
      OP_FINISH      = 3'd6
   } op_type;

   typedef enum logic [2:0] {
      CMD_NONE       = 3'd0,
      CMD_KEY_INIT   = 3'd1,
      CMD_NONCE_INIT = 3'd2,
      CMD_XOR_STEP   = 3'd3,
      CMD_STEP_XOR   = 3'd4,
      CMD_SNAP       = 3'd5,
      CMD_MIX        = 3'd6,
      CMD_MIX_LOAD   = 3'd7
   } cmd_type;

   typedef struct packed {
      cmd_type  cmd;
      logic     fold;
      logic     save;
      word_type xval;
   } ctl_type;

   function automatic word_type rotl(word_type w, int c);
      return (w << c) | (w >> (32 - c));
   endfunction

   function automatic word_type sb1(word_type w);
      word_type r;
      r = w ^ (rotl(w, 5) | rotl(w, 7));
      r = r ^ (rotl(r, 19) | rotl(r, 22));
      return r;
   endfunction

   function automatic word_type sb2(word_type w);
      word_type r;
      r = w ^ (rotl(w, 7) | rotl(w, 22));
      r = r ^ (rotl(r, 5) | rotl(r, 19));
      return r;
   endfunction

   // Fibonacci fill used at key start.
   function automatic sreg_type fib_init();
      sreg_type r;
      r[0] = 32'd1;
      r[1] = 32'd1;
      for (int i = 2; i < REG_WORDS; i++) begin
         r[i] = r[i-1] + r[i-2];
      end
      return r;
   endfunction

   localparam sreg_type FIB_INIT = fib_init();

endpackage

@@ sv/shn_core.sv @@
// ----------------------------------------------------------------------------
// Shannon cipher register core
// Holds the cipher, CRC and saved registers and the single step unit that
// advances the cipher register by one word per step command.
// ----------------------------------------------------------------------------
module shn_core import shn_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  ctl_type  ctl,
   output word_type stream_word
);

   sreg_type stream_ff, stream_in;
   sreg_type crc_ff, crc_in;
   sreg_type saved_ff, saved_in;
   word_type rc_ff, rc_in;
   word_type sw_ff, sw_in;

   sreg_type step_src, step_res, mixed;
   word_type t1, t2;

   always_comb begin
      step_src = stream_ff;
      if (ctl.cmd == CMD_XOR_STEP) begin
         step_src[KEYP] = stream_ff[KEYP] ^ ctl.xval;
      end

      // One register step: shift down, new top word, feedback into word 0.
      t1 = sb1(step_src[12] ^ step_src[13] ^ rc_ff) ^ rotl(step_src[0], 1);
      t2 = sb2(step_src[3] ^ t1);
      for (int i = 0; i < REG_WORDS - 1; i++) begin
         step_res[i] = step_src[i+1];
      end
      step_res[REG_WORDS-1] = t1;
      step_res[0] = step_src[1] ^ t2;

      for (int i = 0; i < REG_WORDS; i++) begin
         mixed[i] = stream_ff[i] ^ crc_ff[i];
      end

      stream_in = stream_ff;
      crc_in    = crc_ff;
      saved_in  = saved_ff;
      rc_in     = rc_ff;
      sw_in     = sw_ff;

      case (ctl.cmd)
         CMD_KEY_INIT: begin
            stream_in = FIB_INIT;
            rc_in     = INITKONST;
         end
         CMD_NONCE_INIT: begin
            stream_in = saved_ff;
            rc_in     = INITKONST;
         end
         CMD_XOR_STEP: begin
            stream_in = step_res;
            sw_in     = t2 ^ step_src[9] ^ step_src[13];
         end
         CMD_STEP_XOR: begin
            stream_in       = step_res;
            stream_in[KEYP] = step_res[KEYP] ^ ctl.xval;
            sw_in           = t2 ^ step_src[9] ^ step_src[13];
         end
         CMD_SNAP: begin
            crc_in = stream_ff;
         end
         CMD_MIX: begin
            stream_in = mixed;
         end
         CMD_MIX_LOAD: begin
            stream_in = mixed;
            rc_in     = mixed[0];
            if (ctl.save) begin
               saved_in = mixed;
            end
         end
         default: begin
         end
      endcase

      // A MAC fold shifts the CRC register and perturbs the cipher register.
      if (ctl.fold) begin
         for (int i = 0; i < REG_WORDS - 1; i++) begin
            crc_in[i] = crc_ff[i+1];
         end
         crc_in[REG_WORDS-1] = crc_ff[0] ^ crc_ff[2] ^ crc_ff[REG_WORDS-1] ^ ctl.xval;
         stream_in[KEYP] = stream_ff[KEYP] ^ ctl.xval;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stream_ff <= '0;
         crc_ff    <= '0;
         saved_ff  <= '0;
         rc_ff     <= '0;
         sw_ff     <= '0;
      end else begin
         stream_ff <= stream_in;
         crc_ff    <= crc_in;
         saved_ff  <= saved_in;
         rc_ff     <= rc_in;
         sw_ff     <= sw_in;
      end
   end

   assign stream_word = sw_ff;

endmodule

@@ sv/shannon_stream_cipher_mac.sv @@
// ----------------------------------------------------------------------------
// Shannon stream cipher with MAC
// Byte command sequencer around a shared register step unit.
// ----------------------------------------------------------------------------
// Commands arrive on the req_ channel, one per transfer; results leave on the
// rsp_ channel through a single output register. req_stall is high whenever
// a command is in progress, so one command is handled at a time.
// Key start, nonce start, load byte and an unused op are done in S_IDLE;
// load end runs S_LEND_A (partial word only), S_LEND_B, S_SNAP, S_DIFF and
// S_LEND_E; encrypt and decrypt run S_CRYPT_STEP and S_CRYPT_OUT and give
// one result; finish runs S_FIN_FOLD, S_FIN_PERT, S_FIN_MIX and S_DIFF, then
// S_FIN_STEP and S_FIN_OUT per MAC word, giving ceil(bytes/4) results
// (bytes capped at 64), the final one marked by rsp_last. A finish asking
// for no bytes gives no result. A result waits in the output register while
// rsp_stall is high and the sequencer holds in its emitting state until the
// register frees. The register frees in the cycle its transfer completes,
// so a new result can be loaded in that cycle. Synchronous reset clears all
// cipher, CRC and saved registers and the counters, and leaves the block
// idle with no result pending.
// ----------------------------------------------------------------------------
`include "shannon_stream_cipher_mac_assert.svh"

module shannon_stream_cipher_mac import shn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [7:0]  req_data_byte,
   input  logic [6:0]  req_mac_bytes,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_out_word,
   output logic [2:0]  rsp_valid_bytes,
   output logic        rsp_last
);

   typedef enum logic [13:0] {
      S_IDLE       = 14'b00000000000001,
      S_LEND_A     = 14'b00000000000010,
      S_LEND_B     = 14'b00000000000100,
      S_SNAP       = 14'b00000000001000,
      S_DIFF       = 14'b00000000010000,
      S_LEND_E     = 14'b00000000100000,
      S_CRYPT_STEP = 14'b00000001000000,
      S_CRYPT_OUT  = 14'b00000010000000,
      S_FIN_FOLD   = 14'b00000100000000,
      S_FIN_PERT   = 14'b00001000000000,
      S_FIN_MIX    = 14'b00010000000000,
      S_FIN_STEP   = 14'b00100000000000,
      S_FIN_OUT    = 14'b01000000000000,
      S_SPARE      = 14'b10000000000000
   } state_type;

   state_type        state_ff, state_in;
   logic [DIFF_W-1:0] diff_cnt_ff, diff_cnt_in;
   logic             fin_ff, fin_in;
   logic [7:0]       byte_ff, byte_in;
   logic             dec_ff, dec_in;
   logic [6:0]       rem_ff, rem_in;
   word_type         mac_accum_ff, mac_accum_in;
   logic [5:0]       bits_left_ff, bits_left_in;
   word_type         load_accum_ff, load_accum_in;
   word_type         load_count_ff, load_count_in;
   logic             key_mode_ff, key_mode_in;

   logic             rsp_valid_ff, rsp_valid_in;
   word_type         rsp_word_ff, rsp_word_in;
   logic [2:0]       rsp_bytes_ff, rsp_bytes_in;
   logic             rsp_last_ff, rsp_last_in;

   ctl_type          ctl;
   word_type         stream_word;
   logic             slot_free;
   logic             accept;
   logic             crypt_go;
   logic             crypt_rsp;

   // Work values for the command being handled.
   word_type         acc_new;
   word_type         cnt_new;
   logic [5:0]       sh;
   logic [7:0]       ks, crypt_out, pt;
   word_type         mac_new;
   logic [5:0]       bl_new;
   logic [2:0]       take;
   word_type         mask;

   shn_core u_core (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .stream_word (stream_word)
   );

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign accept    = req_valid && (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      diff_cnt_in   = diff_cnt_ff;
      fin_in        = fin_ff;
      byte_in       = byte_ff;
      dec_in        = dec_ff;
      rem_in        = rem_ff;
      mac_accum_in  = mac_accum_ff;
      bits_left_in  = bits_left_ff;
      load_accum_in = load_accum_ff;
      load_count_in = load_count_ff;
      key_mode_in   = key_mode_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_word_in   = rsp_word_ff;
      rsp_bytes_in  = rsp_bytes_ff;
      rsp_last_in   = rsp_last_ff;

      ctl.cmd  = CMD_NONE;
      ctl.fold = 1'b0;
      ctl.save = 1'b0;
      ctl.xval = '0;

      acc_new   = load_accum_ff |
                  (word_type'(req_data_byte) << {load_count_ff[1:0], 3'b000});
      cnt_new   = load_count_ff + 32'd1;
      sh        = 6'd32 - bits_left_ff;
      ks        = 8'(stream_word >> sh[4:0]);
      crypt_out = byte_ff ^ ks;
      pt        = dec_ff ? crypt_out : byte_ff;
      mac_new   = mac_accum_ff ^ (word_type'(pt) << sh[4:0]);
      bl_new    = bits_left_ff - 6'd8;
      take      = (rem_ff >= 7'd4) ? 3'd4 : rem_ff[2:0];
      case (take)
         3'd1:    mask = 32'h000000ff;
         3'd2:    mask = 32'h0000ffff;
         3'd3:    mask = 32'h00ffffff;
         default: mask = 32'hffffffff;
      endcase

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_KEY_START: begin
                     ctl.cmd       = CMD_KEY_INIT;
                     load_accum_in = '0;
                     load_count_in = '0;
                     key_mode_in   = 1'b1;
                  end
                  OP_NONCE_START: begin
                     ctl.cmd       = CMD_NONCE_INIT;
                     load_accum_in = '0;
                     load_count_in = '0;
                     key_mode_in   = 1'b0;
                  end
                  OP_LOAD_BYTE: begin
                     load_count_in = cnt_new;
                     if (cnt_new[1:0] == 2'd0) begin
                        ctl.cmd       = CMD_XOR_STEP;
                        ctl.xval      = acc_new;
                        load_accum_in = '0;
                     end else begin
                        load_accum_in = acc_new;
                     end
                  end
                  OP_LOAD_END: begin
                     state_in = (load_count_ff[1:0] != 2'd0) ? S_LEND_A : S_LEND_B;
                  end
                  OP_ENCRYPT, OP_DECRYPT: begin
                     byte_in  = req_data_byte;
                     dec_in   = (req_op == OP_DECRYPT);
                     state_in = S_CRYPT_STEP;
                  end
                  OP_FINISH: begin
                     rem_in   = (req_mac_bytes > 7'(MAC_BYTE_LIMIT)) ?
                                7'(MAC_BYTE_LIMIT) : req_mac_bytes;
                     state_in = S_FIN_FOLD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LEND_A: begin
            // A partial word is folded in zero padded.
            ctl.cmd  = CMD_XOR_STEP;
            ctl.xval = load_accum_ff;
            state_in = S_LEND_B;
         end
         S_LEND_B: begin
            ctl.cmd  = CMD_XOR_STEP;
            ctl.xval = load_count_ff;
            state_in = S_SNAP;
         end
         S_SNAP: begin
            ctl.cmd     = CMD_SNAP;
            diff_cnt_in = '0;
            fin_in      = 1'b0;
            state_in    = S_DIFF;
         end
         S_DIFF: begin
            ctl.cmd     = CMD_XOR_STEP;
            diff_cnt_in = diff_cnt_ff + 1'b1;
            if (diff_cnt_ff == DIFF_W'(REG_WORDS - 1)) begin
               state_in = fin_ff ? S_FIN_STEP : S_LEND_E;
            end
         end
         S_LEND_E: begin
            ctl.cmd       = CMD_MIX_LOAD;
            ctl.save      = key_mode_ff;
            bits_left_in  = '0;
            load_accum_in = '0;
            load_count_in = '0;
            state_in      = S_IDLE;
         end
         S_CRYPT_STEP: begin
            if (bits_left_ff == 6'd0 || bits_left_ff > 6'd32) begin
               ctl.cmd      = CMD_XOR_STEP;
               mac_accum_in = '0;
               bits_left_in = 6'd32;
            end
            state_in = S_CRYPT_OUT;
         end
         S_CRYPT_OUT: begin
            if (slot_free) begin
               mac_accum_in = mac_new;
               bits_left_in = bl_new;
               if (bl_new == 6'd0) begin
                  ctl.fold = 1'b1;
                  ctl.xval = mac_new;
               end
               rsp_valid_in = 1'b1;
               rsp_word_in  = word_type'(crypt_out);
               rsp_bytes_in = 3'd1;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_FIN_FOLD: begin
            if (bits_left_ff != 6'd0) begin
               ctl.fold = 1'b1;
               ctl.xval = mac_accum_ff;
            end
            state_in = S_FIN_PERT;
         end
         S_FIN_PERT: begin
            ctl.cmd      = CMD_STEP_XOR;
            ctl.xval     = INITKONST ^ {23'b0, bits_left_ff, 3'b000};
            bits_left_in = '0;
            state_in     = S_FIN_MIX;
         end
         S_FIN_MIX: begin
            ctl.cmd     = CMD_MIX;
            diff_cnt_in = '0;
            fin_in      = 1'b1;
            state_in    = S_DIFF;
         end
         S_FIN_STEP: begin
            if (rem_ff == 7'd0) begin
               state_in = S_IDLE;
            end else begin
               ctl.cmd  = CMD_XOR_STEP;
               state_in = S_FIN_OUT;
            end
         end
         S_FIN_OUT: begin
            if (slot_free) begin
               rem_in       = rem_ff - 7'(take);
               rsp_valid_in = 1'b1;
               rsp_word_in  = stream_word & mask;
               rsp_bytes_in = take;
               rsp_last_in  = (rem_ff == 7'(take));
               state_in     = (rem_ff == 7'(take)) ? S_IDLE : S_FIN_STEP;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         diff_cnt_ff   <= '0;
         fin_ff        <= 1'b0;
         rem_ff        <= '0;
         mac_accum_ff  <= '0;
         bits_left_ff  <= '0;
         load_accum_ff <= '0;
         load_count_ff <= '0;
         key_mode_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         diff_cnt_ff   <= diff_cnt_in;
         fin_ff        <= fin_in;
         rem_ff        <= rem_in;
         mac_accum_ff  <= mac_accum_in;
         bits_left_ff  <= bits_left_in;
         load_accum_ff <= load_accum_in;
         load_count_ff <= load_count_in;
         key_mode_ff   <= key_mode_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      dec_ff       <= dec_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_bytes_ff <= rsp_bytes_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_word    = rsp_word_ff;
   assign rsp_valid_bytes = rsp_bytes_ff;
   assign rsp_last        = rsp_last_ff;

   assign crypt_go  = (state_ff == S_CRYPT_OUT) && slot_free;
   assign crypt_rsp = rsp_valid_ff && (rsp_bytes_ff == 3'd1) && rsp_last_ff;

   // Keystream bits are only ever consumed a whole byte at a time.
   `SHN_ASSERT(a_bits_left_aligned, bits_left_ff[2:0] == 3'd0 && bits_left_ff <= 6'd32)
   `SHN_ASSERT(a_rem_bounded, rem_ff <= 7'(MAC_BYTE_LIMIT))
   `SHN_ASSERT_NEXT(a_crypt_emits, crypt_go, crypt_rsp && state_ff == S_IDLE)

endmodule

@@ tb/shannon_checker.sv @@
// ----------------------------------------------------------------------------
// Shannon cipher engine checker
// Watches both channels, keeps its own copy of the cipher and MAC state,
// predicts every result of each accepted command and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module shannon_checker import shn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [7:0]  req_data_byte,
   input  logic [6:0]  req_mac_bytes,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_out_word,
   input  logic [2:0]  rsp_valid_bytes,
   input  logic        rsp_last,
   output int          failures,
   output int          pending
);

   typedef struct packed {
      word_type   word;
      logic [2:0] nbytes;
      logic       last;
   } cipher_out_type;

   cipher_out_type cipher_out_due [$];

   word_type    sreg  [REG_WORDS];
   word_type    crc   [REG_WORDS];
   word_type    snap  [REG_WORDS];
   word_type    konst;
   word_type    keystream;
   word_type    mac_word;
   word_type    load_word;
   word_type    load_total;
   int unsigned bits_free;
   bit          loading_key;

   function automatic word_type rol(word_type w, int c);
      return (w << c) | (w >> (32 - c));
   endfunction

   function automatic word_type mix_a(word_type w);
      word_type r;
      r = w ^ (rol(w, 5) | rol(w, 7));
      r = r ^ (rol(r, 19) | rol(r, 22));
      return r;
   endfunction

   function automatic word_type mix_b(word_type w);
      word_type r;
      r = w ^ (rol(w, 7) | rol(w, 22));
      r = r ^ (rol(r, 5) | rol(r, 19));
      return r;
   endfunction

   // One step of the nonlinear shift register, leaving a fresh keystream word.
   function automatic void cycle_reg();
      word_type t;
      t = mix_a(sreg[12] ^ sreg[13] ^ konst) ^ rol(sreg[0], 1);
      for (int n = 1; n < REG_WORDS; n++) sreg[n-1] = sreg[n];
      sreg[REG_WORDS-1] = t;
      t = mix_b(sreg[2] ^ sreg[15]);
      sreg[0] ^= t;
      keystream = t ^ sreg[8] ^ sreg[12];
   endfunction

   function automatic void diffuse();
      for (int n = 0; n < REG_WORDS; n++) cycle_reg();
   endfunction

   function automatic void fold_mac(word_type w);
      word_type t;
      t = crc[0] ^ crc[2] ^ crc[15] ^ w;
      for (int n = 1; n < REG_WORDS; n++) crc[n-1] = crc[n];
      crc[REG_WORDS-1] = t;
      sreg[KEYP] ^= w;
   endfunction

   function automatic void clear_model();
      for (int n = 0; n < REG_WORDS; n++) begin
         sreg[n] = '0;
         crc[n]  = '0;
         snap[n] = '0;
      end
      konst       = '0;
      keystream   = '0;
      mac_word    = '0;
      load_word   = '0;
      load_total  = '0;
      bits_free   = 0;
      loading_key = 1'b0;
      cipher_out_due.delete();
   endfunction

   // End of a key or nonce: pad, fold in the length, diffuse and feed forward.
   function automatic void close_load();
      if (load_total[1:0] != 2'b00) begin
         sreg[KEYP] ^= load_word;
         cycle_reg();
      end
      sreg[KEYP] ^= load_total;
      cycle_reg();
      for (int n = 0; n < REG_WORDS; n++) crc[n] = sreg[n];
      diffuse();
      for (int n = 0; n < REG_WORDS; n++) sreg[n] ^= crc[n];
      konst = sreg[0];
      if (loading_key) begin
         for (int n = 0; n < REG_WORDS; n++) snap[n] = sreg[n];
      end
      bits_free  = 0;
      load_word  = '0;
      load_total = '0;
   endfunction

   function automatic logic [7:0] crypt_byte(logic [7:0] b, bit dec);
      int unsigned sh;
      logic [7:0]  o;
      word_type    plain;
      if (bits_free == 0 || bits_free > 32) begin
         cycle_reg();
         mac_word  = '0;
         bits_free = 32;
      end
      sh    = 32 - bits_free;
      o     = b ^ 8'(keystream >> sh);
      plain = word_type'(dec ? o : b);
      mac_word ^= plain << sh;
      bits_free -= 8;
      if (bits_free == 0) fold_mac(mac_word);
      return o;
   endfunction

   function automatic void finish_mac(logic [6:0] nbytes);
      int unsigned    want;
      int unsigned    chunk;
      word_type       w;
      cipher_out_type item;
      if (bits_free != 0) fold_mac(mac_word);
      cycle_reg();
      sreg[KEYP] ^= INITKONST ^ word_type'((bits_free & 32'h3F) << 3);
      bits_free = 0;
      for (int n = 0; n < REG_WORDS; n++) sreg[n] ^= crc[n];
      diffuse();
      want = 32'(nbytes);
      if (want > MAX_MAC_BYTES) want = MAX_MAC_BYTES;
      if (want > 4 * MAX_RESULTS) want = 4 * MAX_RESULTS;
      while (want > 0) begin
         chunk = (want >= 4) ? 4 : want;
         cycle_reg();
         w = keystream;
         if (chunk < 4) w &= ~(32'hFFFF_FFFF << (8 * chunk));
         want -= chunk;
         item.word   = w;
         item.nbytes = 3'(chunk);
         item.last   = (want == 0);
         cipher_out_due.push_back(item);
      end
   endfunction

   function automatic void run_cipher_cmd(logic [2:0] op, logic [7:0] b, logic [6:0] nbytes);
      cipher_out_type item;
      case (op)
         OP_KEY_START: begin
            sreg[0] = 32'd1;
            sreg[1] = 32'd1;
            for (int n = 2; n < REG_WORDS; n++) sreg[n] = sreg[n-1] + sreg[n-2];
            konst       = INITKONST;
            load_word   = '0;
            load_total  = '0;
            loading_key = 1'b1;
         end
         OP_NONCE_START: begin
            for (int n = 0; n < REG_WORDS; n++) sreg[n] = snap[n];
            konst       = INITKONST;
            load_word   = '0;
            load_total  = '0;
            loading_key = 1'b0;
         end
         OP_LOAD_BYTE: begin
            load_word |= word_type'(b) << (8 * load_total[1:0]);
            load_total++;
            if (load_total[1:0] == 2'b00) begin
               sreg[KEYP] ^= load_word;
               cycle_reg();
               load_word = '0;
            end
         end
         OP_LOAD_END: close_load();
         OP_ENCRYPT, OP_DECRYPT: begin
            item.word   = {24'd0, crypt_byte(b, op == OP_DECRYPT)};
            item.nbytes = 3'd1;
            item.last   = 1'b1;
            cipher_out_due.push_back(item);
         end
         OP_FINISH: finish_mac(nbytes);
         default: ;
      endcase
   endfunction

   function automatic void check_result();
      cipher_out_type exp;
      if (cipher_out_due.size() == 0) begin
         failures++;
         $display("%0t: unexpected result word %h bytes %0d last %b",
                  $time, rsp_out_word, rsp_valid_bytes, rsp_last);
         return;
      end
      exp = cipher_out_due.pop_front();
      if (rsp_out_word !== exp.word) begin
         failures++;
         $display("%0t: out_word expected %h actual %h", $time, exp.word, rsp_out_word);
      end
      if (rsp_valid_bytes !== exp.nbytes) begin
         failures++;
         $display("%0t: valid_bytes expected %0d actual %0d",
                  $time, exp.nbytes, rsp_valid_bytes);
      end
      if (rsp_last !== exp.last) begin
         failures++;
         $display("%0t: last expected %b actual %b", $time, exp.last, rsp_last);
      end
   endfunction

   initial begin
      failures = 0;
      pending  = 0;
      clear_model();
   end

   // Results always belong to commands accepted earlier, so the result side
   // is checked before the new command is folded into the model.
   always @(posedge clock) begin
      if (reset) begin
         clear_model();
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) check_result();
         if (req_valid === 1'b1 && req_stall === 1'b0)
            run_cipher_cmd(req_op, req_data_byte, req_mac_bytes);
      end
      pending = cipher_out_due.size();
   end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Shannon cipher engine testbench
// Drives directed and random command streams with random idling and stalls,
// including a long receiver hold-off, while the checker predicts every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
   import shn_pkg::*;

   localparam logic [2:0] OP_UNUSED = 3'd7;
   localparam int QUIET_LIMIT  = 3000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 80;
   localparam int PHASE_ITEMS  = 16;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_op;
   logic [7:0]  req_data_byte;
   logic [6:0]  req_mac_bytes;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_out_word;
   logic [2:0]  rsp_valid_bytes;
   logic        rsp_last;

   int failures;
   int pending;
   int send_idle_pct;
   int stall_pct;
   int items_sent;
   bit want_hold;

   shannon_stream_cipher_mac dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_data_byte   (req_data_byte),
      .req_mac_bytes   (req_mac_bytes),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_word    (rsp_out_word),
      .rsp_valid_bytes (rsp_valid_bytes),
      .rsp_last        (rsp_last)
   );

   shannon_checker scoreboard (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_data_byte   (req_data_byte),
      .req_mac_bytes   (req_mac_bytes),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_word    (rsp_out_word),
      .rsp_valid_bytes (rsp_valid_bytes),
      .rsp_last        (rsp_last),
      .failures        (failures),
      .pending         (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver side: random stalls, or a long hold-off when one is requested.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (want_hold) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            want_hold = 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // Ends the run if neither channel completes a transfer for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("tb: failure");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   // Valid is left high so that back-to-back commands need no extra edge.
   task automatic send_cmd(logic [2:0] op, logic [7:0] data, logic [6:0] nbytes);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid     <= 1'b0;
         req_op        <= 3'($urandom_range(7));
         req_data_byte <= 8'($urandom_range(255));
         req_mac_bytes <= 7'($urandom_range(127));
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_op        <= op;
      req_data_byte <= data;
      req_mac_bytes <= nbytes;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if (op != OP_UNUSED) items_sent++;
   endtask

   function automatic logic [6:0] pick_mac_len();
      int sel;
      sel = $urandom_range(9);
      if (sel < 6) return 7'($urandom_range(16));
      if (sel < 9) return 7'($urandom_range(64));
      return 7'($urandom_range(65, 127));
   endfunction

   task automatic send_crypt();
      send_cmd($urandom_range(1) ? OP_DECRYPT : OP_ENCRYPT, 8'($urandom_range(255)),
               7'($urandom_range(127)));
   endtask

   // A well-formed session with random content; now and then the start
   // command is dropped so loads act on whatever state is present.
   task automatic run_session();
      int n_load;
      int n_crypt;
      n_load  = $urandom_range(9);
      n_crypt = $urandom_range(1, 9);
      case ($urandom_range(7))
         0, 1:    send_cmd(OP_KEY_START, 8'($urandom_range(255)), 7'($urandom_range(127)));
         2:       ;
         default: send_cmd(OP_NONCE_START, 8'($urandom_range(255)), 7'($urandom_range(127)));
      endcase
      repeat (n_load)
         send_cmd(OP_LOAD_BYTE, 8'($urandom_range(255)), 7'($urandom_range(127)));
      send_cmd(OP_LOAD_END, 8'($urandom_range(255)), 7'($urandom_range(127)));
      repeat (n_crypt) send_crypt();
      send_cmd(OP_FINISH, 8'($urandom_range(255)), pick_mac_len());
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   initial begin
      int target;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_op        = OP_KEY_START;
      req_data_byte = 8'h00;
      req_mac_bytes = 7'd0;
      send_idle_pct = 0;
      stall_pct     = 0;
      items_sent    = 0;
      want_hold     = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: commands before any key, partial and whole-word loads,
      // both directions across a word boundary, ignored op, zero and
      // oversized MAC lengths, and loads with no start command.
      send_cmd(OP_ENCRYPT, 8'h00, 7'd0);
      send_cmd(OP_FINISH, 8'hFF, 7'd3);
      send_cmd(OP_KEY_START, 8'h00, 7'd0);
      send_cmd(OP_LOAD_BYTE, 8'h00, 7'd127);
      send_cmd(OP_LOAD_BYTE, 8'hFF, 7'd0);
      send_cmd(OP_LOAD_BYTE, 8'h5A, 7'd0);
      send_cmd(OP_LOAD_BYTE, 8'hA5, 7'd0);
      send_cmd(OP_LOAD_BYTE, 8'h80, 7'd0);
      send_cmd(OP_LOAD_END, 8'h00, 7'd0);
      send_cmd(OP_NONCE_START, 8'h00, 7'd0);
      send_cmd(OP_LOAD_BYTE, 8'h01, 7'd0);
      send_cmd(OP_LOAD_BYTE, 8'hFE, 7'd0);
      send_cmd(OP_LOAD_BYTE, 8'h7F, 7'd0);
      send_cmd(OP_LOAD_BYTE, 8'hC3, 7'd0);
      send_cmd(OP_LOAD_END, 8'h00, 7'd0);
      send_cmd(OP_ENCRYPT, 8'hFF, 7'd0);
      send_cmd(OP_DECRYPT, 8'h00, 7'd0);
      send_cmd(OP_ENCRYPT, 8'h5A, 7'd0);
      send_cmd(OP_DECRYPT, 8'hA5, 7'd0);
      send_cmd(OP_ENCRYPT, 8'h01, 7'd0);
      send_cmd(OP_UNUSED, 8'hFF, 7'd127);
      send_cmd(OP_FINISH, 8'h00, 7'd0);
      send_cmd(OP_FINISH, 8'h00, 7'd127);
      send_cmd(OP_FINISH, 8'h00, 7'd64);
      send_cmd(OP_LOAD_BYTE, 8'h33, 7'd0);
      send_cmd(OP_LOAD_END, 8'h00, 7'd0);
      send_cmd(OP_FINISH, 8'h00, 7'd5);
      wait_drained();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 54; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 54; end
            default: begin send_idle_pct = 26; stall_pct = 26; end
         endcase
         target = items_sent + PHASE_ITEMS;
         if (phase == 2) begin
            // Long receiver hold-off while commands keep coming, so the
            // output register fills and the block pushes back on its input.
            want_hold = 1'b1;
            send_cmd(OP_FINISH, 8'($urandom_range(255)), 7'd64);
            repeat (6) send_crypt();
         end
         while (items_sent < target) begin
            if ($urandom_range(5) == 0)
               send_cmd(3'($urandom_range(7)), 8'($urandom_range(255)),
                        7'($urandom_range(127)));
            else
               run_session();
            // In the second phase the sender pauses now and then until every result is back.
            if (phase == 1 && $urandom_range(3) == 0) begin
               wait_drained();
               @(negedge clock);
            end
         end
      end

      wait_drained();
      stall_pct = 0;
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (failures == 0 && pending == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+sv
sv/shn_pkg.sv
sv/shn_core.sv
sv/shannon_stream_cipher_mac.sv
tb/shannon_checker.sv
tb/testbench.sv
